/* design/butterworth_freq_mask_weight_macros.svh */
// Assertion macros shared by the Butterworth mask weight design.
// No dependencies; pulled in by the modules that carry assertions.
`ifndef BUTTERWORTH_FREQ_MASK_WEIGHT_MACROS_SVH
`define BUTTERWORTH_FREQ_MASK_WEIGHT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BFM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bfm: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define BFM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bfm: next-cycle check failed");

`endif

/* design/bfm_pkg.sv */
// Shared types, widths, register indexes and helpers for the Butterworth
// mask weight pipeline. No dependencies.
package bfm_pkg;

    localparam int MAX_SIZE  = 4096;
    localparam int MAX_ORDER = 8;

    localparam int SIZE_W  = 13;
    localparam int COORD_W = 12;
    localparam int HALF_W  = 12;
    localparam int FOLD_W  = 11;
    localparam int DIST_W  = 23;
    localparam int R2_W    = 23;
    localparam int NUM_W   = 40;
    localparam int Q_W     = 32;
    localparam int ORD_W   = 4;
    localparam int ORD2_W  = 5;
    localparam int WT_W    = 16;

    // ratio divider: 32 quotient bits, 4 per stage
    localparam int QD_REM_W  = 24;
    localparam int QD_BITS   = 4;
    localparam int QD_STAGES = Q_W / QD_BITS;

    // power chain: one multiply per stage
    localparam int PW_STAGES = 2 * MAX_ORDER;

    // weight divider: 18 quotient bits, 3 per stage
    localparam int WD_NUM_W  = 33;
    localparam int WD_DEN_W  = 33;
    localparam int WD_REM_W  = 34;
    localparam int WD_QBITS  = 18;
    localparam int WD_BITS   = 3;
    localparam int WD_STAGES = WD_QBITS / WD_BITS;

    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ORDER  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd4;

    localparam logic [Q_W-1:0]  Q_ONE = 32'h0001_0000;
    localparam logic [WT_W-1:0] W_ONE = 16'h8000;

    // configuration as seen by the datapath (clamped and derived)
    typedef struct packed {
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        logic [HALF_W-1:0] hw;
        logic [HALF_W-1:0] hh;
        logic [R2_W-1:0]   r2;
        logic [ORD2_W-1:0] order2;
        logic              mode;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        w:      13'd512,
        h:      13'd512,
        hw:     12'd256,
        hh:     12'd256,
        r2:     23'd2500,
        order2: 5'd4,
        mode:   1'b0
    };

    // Q16.16 multiply, round half up, saturate to 32 bits
    function automatic logic [Q_W-1:0] qmul(input logic [Q_W-1:0] a,
                                            input logic [Q_W-1:0] b);
        logic [2*Q_W-1:0] prod;
        prod = {{Q_W{1'b0}}, a} * {{Q_W{1'b0}}, b} + 64'd32768;
        if (prod[2*Q_W-1:Q_W+16] != '0) begin
            return '1;
        end
        return prod[Q_W+15:16];
    endfunction

endpackage

/* design/butterworth_freq_mask_weight.sv */
// Top level of the Butterworth frequency mask weight generator: config
// registers, pipeline control and the output register.
// Depends on bfm_pkg, bfm_prep, bfm_qdiv, bfm_power, bfm_wdiv.
//
//   port group   dir   payload                    transfer
//   s_*          in    col, row coordinate        s_tvalid & s_tready
//   m_*          out   weight, Q1.15              m_tvalid & m_tready
//   cfg_*        in    register index + data      cfg_we
//
// One coordinate per clock while a stall on m_tready does not hold the pipeline.
// Stages in order: fold/distance, ratio divider, power chain, weight divider, output register.
// Reset (aresetn low, synchronous) clears all valid bits and restores the
// default configuration. A stall on m_tready freezes the whole pipeline;
// bubbles still let s_tready stay high while the output register is free.
`include "butterworth_freq_mask_weight_macros.svh"

module butterworth_freq_mask_weight (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // [11:0] col, [23:12] row
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [15:0] weight
    input  logic                              cfg_we,
    input  logic [bfm_pkg::REG_IDX_W-1:0]     cfg_addr,
    input  logic [bfm_pkg::SIZE_W-1:0]        cfg_wdata
);

    // raw registers as written
    logic [bfm_pkg::SIZE_W-1:0]  width_reg, height_reg;
    logic [bfm_pkg::COORD_W-1:0] radius_reg;
    logic [bfm_pkg::ORD_W-1:0]   order_reg;
    logic                        mode_reg;

    // clamped and derived view, registered from the raw registers
    bfm_pkg::cfg_t cfg_reg, cfg_next;
    // fold stage view: sizes straight from the raw registers
    bfm_pkg::cfg_t cfg_cur;

    logic [bfm_pkg::HALF_W-1:0]  r_lim1, r_lim;
    logic [bfm_pkg::ORD_W-1:0]   order_clamp;

    logic                        en;
    logic                        m_valid_reg;
    logic [bfm_pkg::WT_W-1:0]    m_data_reg, m_data_next;
    logic [bfm_pkg::WT_W-1:0]    wt_clamp;
    logic [bfm_pkg::WT_W-1:0]    fill_wt;

    logic                        prep_vld, prep_fill;
    logic [bfm_pkg::NUM_W-1:0]   prep_num;
    logic                        qd_vld, qd_fill;
    logic [bfm_pkg::Q_W-1:0]     qd_q;
    logic                        pw_vld, pw_fill;
    logic [bfm_pkg::Q_W-1:0]     pw_p;
    logic                        wd_vld, wd_fill;
    logic [bfm_pkg::WD_QBITS-1:0] wd_quo;

    // register write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 13'd512;
            height_reg <= 13'd512;
            radius_reg <= 12'd50;
            order_reg  <= 4'd2;
            mode_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                bfm_pkg::REG_WIDTH:  width_reg  <= cfg_wdata;
                bfm_pkg::REG_HEIGHT: height_reg <= cfg_wdata;
                bfm_pkg::REG_RADIUS: radius_reg <= cfg_wdata[bfm_pkg::COORD_W-1:0];
                bfm_pkg::REG_ORDER:  order_reg  <= cfg_wdata[bfm_pkg::ORD_W-1:0];
                bfm_pkg::REG_MODE:   mode_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // sizes clamp to MAX_SIZE, radius to both half sizes, order to MAX_ORDER
    always_comb begin
        cfg_next.w = (width_reg > bfm_pkg::SIZE_W'(bfm_pkg::MAX_SIZE))
                   ? bfm_pkg::SIZE_W'(bfm_pkg::MAX_SIZE) : width_reg;
        cfg_next.h = (height_reg > bfm_pkg::SIZE_W'(bfm_pkg::MAX_SIZE))
                   ? bfm_pkg::SIZE_W'(bfm_pkg::MAX_SIZE) : height_reg;
        cfg_next.hw = cfg_next.w[bfm_pkg::SIZE_W-1:1];
        cfg_next.hh = cfg_next.h[bfm_pkg::SIZE_W-1:1];
        r_lim1 = (radius_reg > cfg_next.hw) ? cfg_next.hw : radius_reg;
        r_lim  = (r_lim1 > cfg_next.hh) ? cfg_next.hh : r_lim1;
        cfg_next.r2 = bfm_pkg::R2_W'({12'b0, r_lim} * {12'b0, r_lim});
        order_clamp = (order_reg > bfm_pkg::ORD_W'(bfm_pkg::MAX_ORDER))
                    ? bfm_pkg::ORD_W'(bfm_pkg::MAX_ORDER) : order_reg;
        cfg_next.order2 = {order_clamp, 1'b0};
        cfg_next.mode = mode_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= bfm_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // fold runs in the accept cycle, so a request right after a write must
    // see the new sizes; r2 and the rest are read in later stages
    always_comb begin
        cfg_cur    = cfg_reg;
        cfg_cur.w  = cfg_next.w;
        cfg_cur.h  = cfg_next.h;
        cfg_cur.hw = cfg_next.hw;
        cfg_cur.hh = cfg_next.hh;
    end

    // whole pipeline advances unless a finished result is held back
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    bfm_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_cur),
        .in_valid  (s_tvalid),
        .in_col    (s_tdata[11:0]),
        .in_row    (s_tdata[23:12]),
        .out_valid (prep_vld),
        .out_num   (prep_num),
        .out_fill  (prep_fill)
    );

    bfm_qdiv u_qdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (prep_vld),
        .in_num    (prep_num),
        .in_fill   (prep_fill),
        .out_valid (qd_vld),
        .out_q     (qd_q),
        .out_fill  (qd_fill)
    );

    bfm_power u_power (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (qd_vld),
        .in_q      (qd_q),
        .in_fill   (qd_fill),
        .out_valid (pw_vld),
        .out_p     (pw_p),
        .out_fill  (pw_fill)
    );

    bfm_wdiv u_wdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pw_vld),
        .in_p      (pw_p),
        .in_fill   (pw_fill),
        .out_valid (wd_vld),
        .out_quo   (wd_quo),
        .out_fill  (wd_fill)
    );

    // clamp to 1.0, apply fill value and high-pass complement
    always_comb begin
        fill_wt  = cfg_reg.mode ? bfm_pkg::W_ONE : '0;
        wt_clamp = (wd_quo > {2'b0, bfm_pkg::W_ONE})
                 ? bfm_pkg::W_ONE : wd_quo[bfm_pkg::WT_W-1:0];
        if (wd_fill) begin
            m_data_next = fill_wt;
        end else if (cfg_reg.mode) begin
            m_data_next = bfm_pkg::W_ONE - wt_clamp;
        end else begin
            m_data_next = wt_clamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= wd_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // weight never above 1.0
    `BFM_ASSERT_IMP(a_top_wt_range, aclk, aresetn, m_valid_reg, m_data_reg <= bfm_pkg::W_ONE)
    // fill entries come out as the fill value of the mode in force
    `BFM_ASSERT_NXT(a_top_fill, aclk, aresetn, en && wd_vld && wd_fill, m_data_reg == $past(fill_wt))

endmodule

/* design/bfm_prep.sv */
// Front end: corner folding, fill detection, squared distance and the
// rounded ratio numerator. Depends on bfm_pkg.
module bfm_prep (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  bfm_pkg::cfg_t                    cfg,
    input  logic                             in_valid,
    input  logic [bfm_pkg::COORD_W-1:0]      in_col,
    input  logic [bfm_pkg::COORD_W-1:0]      in_row,
    output logic                             out_valid,
    output logic [bfm_pkg::NUM_W-1:0]        out_num,
    output logic                             out_fill
);

    logic                           a_vld_reg;
    logic [bfm_pkg::FOLD_W-1:0]     a_fx_reg, a_fy_reg;
    logic                           a_fill_reg;
    logic                           b_vld_reg;
    logic [bfm_pkg::NUM_W-1:0]      b_num_reg;
    logic                           b_fill_reg;

    logic [bfm_pkg::SIZE_W-1:0]     col_ext, row_ext, fx_full, fy_full;
    logic                           x_bad, y_bad;
    logic [bfm_pkg::DIST_W-1:0]     dist_sum;
    logic [bfm_pkg::NUM_W-1:0]      num_next;

    // fold to the nearest corner; outside or odd middle line means fill
    always_comb begin
        col_ext = {1'b0, in_col};
        row_ext = {1'b0, in_row};
        fx_full = (col_ext < {1'b0, cfg.hw}) ? col_ext : cfg.w - 13'd1 - col_ext;
        fy_full = (row_ext < {1'b0, cfg.hh}) ? row_ext : cfg.h - 13'd1 - row_ext;
        x_bad   = (col_ext >= cfg.w) || (fx_full >= {1'b0, cfg.hw});
        y_bad   = (row_ext >= cfg.h) || (fy_full >= {1'b0, cfg.hh});
    end

    always_comb begin
        dist_sum = bfm_pkg::DIST_W'({11'b0, a_fx_reg} * {11'b0, a_fx_reg})
                 + bfm_pkg::DIST_W'({11'b0, a_fy_reg} * {11'b0, a_fy_reg});
        num_next = {1'b0, dist_sum, 16'h0000} + {18'b0, cfg.r2[bfm_pkg::R2_W-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_fx_reg   <= fx_full[bfm_pkg::FOLD_W-1:0];
            a_fy_reg   <= fy_full[bfm_pkg::FOLD_W-1:0];
            a_fill_reg <= x_bad || y_bad;
            b_num_reg  <= num_next;
            b_fill_reg <= a_fill_reg;
        end
    end

    assign out_valid = b_vld_reg;
    assign out_num   = b_num_reg;
    assign out_fill  = b_fill_reg;

endmodule

/* design/bfm_qdiv.sv */
// Pipelined restoring divider for the Q16.16 ratio, four quotient bits
// per stage, with saturation decided at entry. Depends on bfm_pkg.
`include "butterworth_freq_mask_weight_macros.svh"

module bfm_qdiv (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  bfm_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    input  logic [bfm_pkg::NUM_W-1:0]   in_num,
    input  logic                        in_fill,
    output logic                        out_valid,
    output logic [bfm_pkg::Q_W-1:0]     out_q,
    output logic                        out_fill
);

    localparam int NS = bfm_pkg::QD_STAGES + 1;

    logic [NS-1:0]                  vld_reg;
    logic [NS-1:0]                  sat_reg;
    logic [NS-1:0]                  fill_reg;
    logic [bfm_pkg::QD_REM_W-1:0]   rem_reg  [NS];
    logic [bfm_pkg::Q_W-1:0]        lo_reg   [NS];
    logic [bfm_pkg::Q_W-1:0]        quo_reg  [NS];
    logic [bfm_pkg::QD_REM_W-1:0]   rem_next [NS];
    logic [bfm_pkg::Q_W-1:0]        lo_next  [NS];
    logic [bfm_pkg::Q_W-1:0]        quo_next [NS];
    logic                           sat_in;

    // quotient exceeds 32 bits iff the top numerator bits reach r2
    assign sat_in = {15'b0, in_num[bfm_pkg::NUM_W-1:bfm_pkg::Q_W]} >= cfg.r2;

    always_comb begin
        logic [bfm_pkg::QD_REM_W-1:0] rem_v;
        logic [bfm_pkg::Q_W-1:0]      lo_v, quo_v;
        rem_next[0] = {16'b0, in_num[bfm_pkg::NUM_W-1:bfm_pkg::Q_W]};
        lo_next[0]  = in_num[bfm_pkg::Q_W-1:0];
        quo_next[0] = '0;
        for (int s = 1; s < NS; s++) begin
            rem_v = rem_reg[s-1];
            lo_v  = lo_reg[s-1];
            quo_v = quo_reg[s-1];
            for (int j = 0; j < bfm_pkg::QD_BITS; j++) begin
                rem_v = {rem_v[bfm_pkg::QD_REM_W-2:0], lo_v[bfm_pkg::Q_W-1]};
                lo_v  = {lo_v[bfm_pkg::Q_W-2:0], 1'b0};
                if (rem_v >= {1'b0, cfg.r2}) begin
                    rem_v = rem_v - {1'b0, cfg.r2};
                    quo_v = {quo_v[bfm_pkg::Q_W-2:0], 1'b1};
                end else begin
                    quo_v = {quo_v[bfm_pkg::Q_W-2:0], 1'b0};
                end
            end
            rem_next[s] = rem_v;
            lo_next[s]  = lo_v;
            quo_next[s] = quo_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sat_reg  <= {sat_reg[NS-2:0], sat_in};
            fill_reg <= {fill_reg[NS-2:0], in_fill};
            for (int s = 0; s < NS; s++) begin
                rem_reg[s] <= rem_next[s];
                lo_reg[s]  <= lo_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_q     = sat_reg[NS-1] ? '1 : quo_reg[NS-1];
    assign out_fill  = fill_reg[NS-1];

    // zero radius must always take the saturated path
    `BFM_ASSERT_NXT(a_qdiv_zero_r2_sat, aclk, aresetn, en && in_valid && (cfg.r2 == '0), sat_reg[0])

endmodule

/* design/bfm_power.sv */
// Power chain: raises the ratio to 2n with one rounded Q16.16 multiply
// per stage; stages past 2n pass through. Depends on bfm_pkg.
`include "butterworth_freq_mask_weight_macros.svh"

module bfm_power (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  bfm_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    input  logic [bfm_pkg::Q_W-1:0]     in_q,
    input  logic                        in_fill,
    output logic                        out_valid,
    output logic [bfm_pkg::Q_W-1:0]     out_p,
    output logic                        out_fill
);

    localparam int NS = bfm_pkg::PW_STAGES;

    logic [NS-1:0]              vld_reg;
    logic [NS-1:0]              fill_reg;
    logic [bfm_pkg::Q_W-1:0]    p_reg  [NS];
    logic [bfm_pkg::Q_W-1:0]    q_reg  [NS];
    logic [bfm_pkg::Q_W-1:0]    p_next [NS];

    // first multiply by q from 1.0 is exact, so stage 0 just loads q
    always_comb begin
        p_next[0] = (cfg.order2 == '0) ? bfm_pkg::Q_ONE : in_q;
        for (int s = 1; s < NS; s++) begin
            if (bfm_pkg::ORD2_W'(s) < cfg.order2) begin
                p_next[s] = bfm_pkg::qmul(p_reg[s-1], q_reg[s-1]);
            end else begin
                p_next[s] = p_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fill_reg <= {fill_reg[NS-2:0], in_fill};
            q_reg[0] <= in_q;
            for (int s = 1; s < NS; s++) begin
                q_reg[s] <= q_reg[s-1];
            end
            for (int s = 0; s < NS; s++) begin
                p_reg[s] <= p_next[s];
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_p     = p_reg[NS-1];
    assign out_fill  = fill_reg[NS-1];

    // a stall freezes every stage
    `BFM_ASSERT_NXT(a_power_stall_hold, aclk, aresetn, !en, $stable(vld_reg))

endmodule

/* design/bfm_wdiv.sv */
// Pipelined restoring divider for round(2^31 / (1 + p)), three quotient
// bits per stage. Depends on bfm_pkg.
module bfm_wdiv (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [bfm_pkg::Q_W-1:0]       in_p,
    input  logic                          in_fill,
    output logic                          out_valid,
    output logic [bfm_pkg::WD_QBITS-1:0]  out_quo,
    output logic                          out_fill
);

    localparam int NS = bfm_pkg::WD_STAGES + 1;

    logic [NS-1:0]                  vld_reg;
    logic [NS-1:0]                  fill_reg;
    logic [bfm_pkg::WD_REM_W-1:0]   rem_reg  [NS];
    logic [bfm_pkg::WD_QBITS-1:0]   lo_reg   [NS];
    logic [bfm_pkg::WD_QBITS-1:0]   quo_reg  [NS];
    logic [bfm_pkg::WD_DEN_W-1:0]   den_reg  [NS];
    logic [bfm_pkg::WD_REM_W-1:0]   rem_next [NS];
    logic [bfm_pkg::WD_QBITS-1:0]   lo_next  [NS];
    logic [bfm_pkg::WD_QBITS-1:0]   quo_next [NS];
    logic [bfm_pkg::WD_DEN_W-1:0]   den_in;
    logic [bfm_pkg::WD_NUM_W-1:0]   num_in;

    always_comb begin
        den_in = {1'b0, bfm_pkg::Q_ONE} + {1'b0, in_p};
        num_in = 33'h0_8000_0000 + {1'b0, den_in[bfm_pkg::WD_DEN_W-1:1]};
    end

    always_comb begin
        logic [bfm_pkg::WD_REM_W-1:0] rem_v;
        logic [bfm_pkg::WD_QBITS-1:0] lo_v, quo_v;
        rem_next[0] = {19'b0, num_in[bfm_pkg::WD_NUM_W-1:bfm_pkg::WD_QBITS]};
        lo_next[0]  = num_in[bfm_pkg::WD_QBITS-1:0];
        quo_next[0] = '0;
        for (int s = 1; s < NS; s++) begin
            rem_v = rem_reg[s-1];
            lo_v  = lo_reg[s-1];
            quo_v = quo_reg[s-1];
            for (int j = 0; j < bfm_pkg::WD_BITS; j++) begin
                rem_v = {rem_v[bfm_pkg::WD_REM_W-2:0], lo_v[bfm_pkg::WD_QBITS-1]};
                lo_v  = {lo_v[bfm_pkg::WD_QBITS-2:0], 1'b0};
                if (rem_v >= {1'b0, den_reg[s-1]}) begin
                    rem_v = rem_v - {1'b0, den_reg[s-1]};
                    quo_v = {quo_v[bfm_pkg::WD_QBITS-2:0], 1'b1};
                end else begin
                    quo_v = {quo_v[bfm_pkg::WD_QBITS-2:0], 1'b0};
                end
            end
            rem_next[s] = rem_v;
            lo_next[s]  = lo_v;
            quo_next[s] = quo_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fill_reg   <= {fill_reg[NS-2:0], in_fill};
            den_reg[0] <= den_in;
            for (int s = 1; s < NS; s++) begin
                den_reg[s] <= den_reg[s-1];
            end
            for (int s = 0; s < NS; s++) begin
                rem_reg[s] <= rem_next[s];
                lo_reg[s]  <= lo_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_quo   = quo_reg[NS-1];
    assign out_fill  = fill_reg[NS-1];

endmodule
